FILE: rtl/mfb_pkg.sv
// shared types and constants for the monochrome framebuffer text rasterizer
// used by mfb_mac and mono_framebuffer_text_rasterizer; no dependencies
package mfb_pkg;

  localparam int FRAME_BYTES_DEF = 1024;
  localparam int FONT_WORDS_DEF  = 4096;
  localparam int FIRST_CHAR_DEF  = 32;

  localparam logic [7:0] WIDTH_RST   = 8'd128;
  localparam logic [6:0] HEIGHT_RST  = 7'd64;
  localparam logic [4:0] GLYPH_W_RST = 5'd7;
  localparam logic [5:0] GLYPH_H_RST = 6'd10;

  localparam logic [7:0] FILL_WHITE = 8'hFF;
  localparam logic [7:0] FILL_BLACK = 8'h00;

  // configuration register indexes
  typedef enum logic [1:0] {
    CFG_WIDTH   = 2'd0,
    CFG_HEIGHT  = 2'd1,
    CFG_GLYPH_W = 2'd2,
    CFG_GLYPH_H = 2'd3
  } cfg_idx_t;

  typedef enum logic [2:0] {
    CMD_PIXEL  = 3'd0,
    CMD_CURSOR = 3'd1,
    CMD_CHAR   = 3'd2,
    CMD_FILL   = 3'd3,
    CMD_FONT   = 3'd4
  } cmd_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CH_BASE,
    ST_ROW,
    ST_PIX_RD,
    ST_PIX_WR,
    ST_FILL_N,
    ST_FILL,
    ST_RDBK,
    ST_LOAD
  } state_t;

  // request to the shared multiply-add unit: result = a * b + c
  typedef struct packed {
    logic       load;
    logic [7:0] a;
    logic [7:0] b;
    logic [7:0] c;
  } mac_req_t;

endpackage

FILE: rtl/mfb_mac.sv
// shared multiply-add unit with registered result
// depends on mfb_pkg for the request struct
module mfb_mac
  import mfb_pkg::*;
(
  input  logic        clk,
  input  mac_req_t    req,
  output logic [15:0] prod
);

  logic [15:0] mul;
  logic [15:0] sum;

  assign mul = 16'(req.a) * 16'(req.b);
  assign sum = mul + 16'(req.c);

  always_ff @(posedge clk) begin
    if (req.load) begin
      prod <= sum;
    end
  end

endmodule

FILE: rtl/mono_framebuffer_text_rasterizer.sv
// top level: monochrome page framebuffer with pixel, fill and text commands
// depends on mfb_pkg and the shared multiply-add unit mfb_mac
//
// channel  direction  handshake              payload
// input    in         in_valid / in_stall    command pos_x pos_y ink char_code
//                                            font_index font_bits read_index
// result   out        out_valid / out_stall  ok char_echo read_byte
// config   in         cfg_write              cfg_index cfg_data
//
// steps: every command ends with a readback of the frame store and the load of the result
//   beat; draw pixel first does one read-modify-write of the frame store, fill writes each
//   byte it fills, and write char reads one font row per glyph row
//   (one read-modify-write of the frame store per glyph pixel)
// one command at a time: in_stall is high from accept until the result beat
//   is loaded into the output register
// reset clears the sequencer, cursor, config and output valid; stores keep
//   their contents, so fill before reading the frame
// a stalled result holds the output register; the next command may be
//   accepted while it waits, and its result waits in the final state
module mono_framebuffer_text_rasterizer
  import mfb_pkg::*;
#(
  parameter int FRAME_BYTES = FRAME_BYTES_DEF,
  parameter int FONT_WORDS  = FONT_WORDS_DEF,
  parameter int FIRST_CHAR  = FIRST_CHAR_DEF
) (
  input  logic        clk,
  input  logic        rst,
  // configuration writes
  input  logic        cfg_write,
  input  logic [1:0]  cfg_index,
  input  logic [7:0]  cfg_data,
  // command beats
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [2:0]  command,
  input  logic [7:0]  pos_x,
  input  logic [7:0]  pos_y,
  input  logic        ink,
  input  logic [7:0]  char_code,
  input  logic [11:0] font_index,
  input  logic [15:0] font_bits,
  input  logic [9:0]  read_index,
  // result beats
  output logic        out_valid,
  input  logic        out_stall,
  output logic        ok,
  output logic [7:0]  char_echo,
  output logic [7:0]  read_byte
);

  localparam int FB_AW   = $clog2(FRAME_BYTES);
  localparam int FB_CW   = $clog2(FRAME_BYTES + 1);
  localparam int FONT_AW = $clog2(FONT_WORDS);

  // configuration registers
  logic [7:0] disp_w;
  logic [6:0] disp_h;
  logic [4:0] glyph_w;
  logic [5:0] glyph_h;

  always_ff @(posedge clk) begin
    if (rst) begin
      disp_w  <= WIDTH_RST;
      disp_h  <= HEIGHT_RST;
      glyph_w <= GLYPH_W_RST;
      glyph_h <= GLYPH_H_RST;
    end else if (cfg_write) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_WIDTH:   disp_w  <= cfg_data;
        CFG_HEIGHT:  disp_h  <= cfg_data[6:0];
        CFG_GLYPH_W: glyph_w <= cfg_data[4:0];
        CFG_GLYPH_H: glyph_h <= cfg_data[5:0];
      endcase
    end
  end

  // sequencer state and working registers
  state_t              state, state_next;
  logic [7:0]          cursor_col, cursor_col_next;
  logic [7:0]          cursor_row, cursor_row_next;
  logic [FONT_AW-1:0]  glyph_base, glyph_base_next;
  logic [5:0]          row_cnt, row_cnt_next;
  logic [4:0]          col_cnt, col_cnt_next;
  logic [FB_CW-1:0]    fill_cnt, fill_cnt_next;
  logic [FB_CW-1:0]    fill_lim, fill_lim_next;
  logic [2:0]          pix_bit, pix_bit_next;
  logic                res_ok, res_ok_next;
  logic [7:0]          res_echo, res_echo_next;
  logic                rd_zero, rd_zero_next;

  // latched command beat
  cmd_t       item_cmd;
  logic       item_ink;
  logic [7:0] item_code;
  logic [9:0] item_ridx;

  logic accept;
  logic out_load;

  // shared multiply-add unit
  mac_req_t    mac_req;
  logic [15:0] prod;

  mfb_mac u_mac (
    .clk  (clk),
    .req  (mac_req),
    .prod (prod)
  );

  // frame store: one write and one registered read per cycle
  logic [7:0]       fb_mem [FRAME_BYTES];
  logic             fb_we, fb_re;
  logic [FB_AW-1:0] fb_waddr, fb_raddr;
  logic [7:0]       fb_wdata, fb_rdata;

  always_ff @(posedge clk) begin
    if (fb_we) begin
      fb_mem[fb_waddr] <= fb_wdata;
    end
    if (fb_re) begin
      fb_rdata <= fb_mem[fb_raddr];
    end
  end

  // font store: written from the command beat, read once per glyph row
  logic [15:0]        font_mem [FONT_WORDS];
  logic               font_we, font_re;
  logic [FONT_AW-1:0] font_waddr, font_raddr;
  logic [15:0]        font_rdata;

  always_ff @(posedge clk) begin
    if (font_we) begin
      font_mem[font_waddr] <= font_bits;
    end
    if (font_re) begin
      font_rdata <= font_mem[font_raddr];
    end
  end

  assign in_stall = (state != ST_IDLE);
  assign accept   = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (accept) begin
      item_cmd  <= cmd_t'(command);
      item_ink  <= ink;
      item_code <= char_code;
      item_ridx <= read_index;
    end
  end

  // shared helpers
  logic [8:0] glyph_y;      // pixel row of the current glyph row
  logic [5:0] col_inc;      // next glyph column
  logic       pix_on;       // font bit of the current glyph column
  logic       pix_color;
  logic       pix_in_store;
  logic       char_fits;
  logic       font_ok;

  assign glyph_y      = 9'(cursor_row) + 9'(row_cnt);
  assign col_inc      = 6'(col_cnt) + 6'd1;
  assign pix_on       = !col_cnt[4] && font_rdata[4'd15 - col_cnt[3:0]];
  assign pix_color    = (item_cmd == CMD_CHAR) ? (pix_on ? item_ink : !item_ink) : item_ink;
  assign pix_in_store = (prod < 16'(FRAME_BYTES));
  // glyph must fit on screen and the code must not lie below the first font character
  assign char_fits = (9'(cursor_col) + 9'(glyph_w) <= 9'(disp_w))
                  && (9'(cursor_row) + 9'(glyph_h) <= 9'(disp_h))
                  && (char_code >= 8'(FIRST_CHAR));
  assign font_ok   = (32'(font_index) < 32'(FONT_WORDS));

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      cursor_col <= '0;
      cursor_row <= '0;
    end else begin
      state      <= state_next;
      cursor_col <= cursor_col_next;
      cursor_row <= cursor_row_next;
    end
  end

  always_ff @(posedge clk) begin
    glyph_base <= glyph_base_next;
    row_cnt    <= row_cnt_next;
    col_cnt    <= col_cnt_next;
    fill_cnt   <= fill_cnt_next;
    fill_lim   <= fill_lim_next;
    pix_bit    <= pix_bit_next;
    res_ok     <= res_ok_next;
    res_echo   <= res_echo_next;
    rd_zero    <= rd_zero_next;
  end

  always_comb begin
    state_next      = state;
    cursor_col_next = cursor_col;
    cursor_row_next = cursor_row;
    glyph_base_next = glyph_base;
    row_cnt_next    = row_cnt;
    col_cnt_next    = col_cnt;
    fill_cnt_next   = fill_cnt;
    fill_lim_next   = fill_lim;
    pix_bit_next    = pix_bit;
    res_ok_next     = res_ok;
    res_echo_next   = res_echo;
    rd_zero_next    = rd_zero;
    mac_req         = '0;
    fb_we           = 1'b0;
    fb_re           = 1'b0;
    fb_waddr        = FB_AW'(prod);
    fb_raddr        = FB_AW'(prod);
    fb_wdata        = fb_rdata;
    font_we         = 1'b0;
    font_re         = 1'b0;
    font_waddr      = FONT_AW'(font_index);
    font_raddr      = FONT_AW'(glyph_base + FONT_AW'(row_cnt));
    out_load        = 1'b0;

    unique case (state)
      ST_IDLE: begin
        if (in_valid) begin
          res_ok_next   = 1'b0;
          res_echo_next = 8'd0;
          state_next    = ST_RDBK;
          case (cmd_t'(command))
            CMD_PIXEL: begin
              if (pos_x < disp_w && pos_y < 8'(disp_h)) begin
                mac_req.load = 1'b1;
                mac_req.a    = 8'(pos_y[7:3]);
                mac_req.b    = disp_w;
                mac_req.c    = pos_x;
                pix_bit_next = pos_y[2:0];
                state_next   = ST_PIX_RD;
              end
            end
            CMD_CURSOR: begin
              cursor_col_next = pos_x;
              cursor_row_next = pos_y;
              res_ok_next     = 1'b1;
            end
            CMD_CHAR: begin
              if (char_fits) begin
                mac_req.load = 1'b1;
                mac_req.a    = char_code - 8'(FIRST_CHAR);
                mac_req.b    = 8'(glyph_h);
                state_next   = ST_CH_BASE;
              end
            end
            CMD_FILL: begin
              mac_req.load = 1'b1;
              mac_req.a    = disp_w;
              mac_req.b    = 8'(disp_h);
              state_next   = ST_FILL_N;
            end
            CMD_FONT: begin
              font_we     = font_ok;
              res_ok_next = font_ok;
            end
            default: begin
              // unknown codes: no effect, failure reported
            end
          endcase
        end
      end

      ST_CH_BASE: begin
        if (17'(prod) + 17'(glyph_h) > 17'(FONT_WORDS)) begin
          state_next = ST_RDBK;
        end else if (glyph_w == 5'd0 || glyph_h == 6'd0) begin
          cursor_col_next = cursor_col + 8'(glyph_w);
          res_ok_next     = 1'b1;
          res_echo_next   = item_code;
          state_next      = ST_RDBK;
        end else begin
          glyph_base_next = FONT_AW'(prod);
          row_cnt_next    = 6'd0;
          state_next      = ST_ROW;
        end
      end

      ST_ROW: begin
        font_re      = 1'b1;
        mac_req.load = 1'b1;
        mac_req.a    = 8'(glyph_y[8:3]);
        mac_req.b    = disp_w;
        mac_req.c    = cursor_col;
        pix_bit_next = glyph_y[2:0];
        col_cnt_next = 5'd0;
        state_next   = ST_PIX_RD;
      end

      ST_PIX_RD: begin
        fb_re      = 1'b1;
        state_next = ST_PIX_WR;
      end

      ST_PIX_WR: begin
        fb_we = pix_in_store;
        if (pix_color) begin
          fb_wdata = fb_rdata | (8'd1 << pix_bit);
        end else begin
          fb_wdata = fb_rdata & ~(8'd1 << pix_bit);
        end
        if (item_cmd != CMD_CHAR) begin
          res_ok_next = pix_in_store;
          state_next  = ST_RDBK;
        end else if (col_inc < 6'(glyph_w)) begin
          col_cnt_next = col_inc[4:0];
          mac_req.load = 1'b1;
          mac_req.a    = 8'(glyph_y[8:3]);
          mac_req.b    = disp_w;
          mac_req.c    = cursor_col + 8'(col_inc);
          state_next   = ST_PIX_RD;
        end else if (7'(row_cnt) + 7'd1 < 7'(glyph_h)) begin
          row_cnt_next = row_cnt + 6'd1;
          state_next   = ST_ROW;
        end else begin
          cursor_col_next = cursor_col + 8'(glyph_w);
          res_ok_next     = 1'b1;
          res_echo_next   = item_code;
          state_next      = ST_RDBK;
        end
      end

      ST_FILL_N: begin
        // bytes to fill: width * height / 8, capped at the store size
        if (32'(prod[15:3]) > 32'(FRAME_BYTES)) begin
          fill_lim_next = FB_CW'(FRAME_BYTES);
        end else begin
          fill_lim_next = FB_CW'(prod[15:3]);
        end
        fill_cnt_next = '0;
        state_next    = ST_FILL;
      end

      ST_FILL: begin
        if (fill_cnt < fill_lim) begin
          fb_we         = 1'b1;
          fb_waddr      = FB_AW'(fill_cnt);
          fb_wdata      = item_ink ? FILL_WHITE : FILL_BLACK;
          fill_cnt_next = fill_cnt + FB_CW'(1);
        end else begin
          res_ok_next = 1'b1;
          state_next  = ST_RDBK;
        end
      end

      ST_RDBK: begin
        fb_re        = 1'b1;
        fb_raddr     = FB_AW'(item_ridx);
        rd_zero_next = !(32'(item_ridx) < 32'(FRAME_BYTES));
        state_next   = ST_LOAD;
      end

      ST_LOAD: begin
        if (!out_valid || !out_stall) begin
          out_load   = 1'b1;
          state_next = ST_IDLE;
        end
      end

      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      ok        <= res_ok;
      char_echo <= res_echo;
      read_byte <= rd_zero ? 8'd0 : fb_rdata;
    end
  end

  // one command in flight: the cycle after an accept is always busy
  assert property (@(posedge clk) disable iff (rst)
    accept |=> in_stall)
    else $error("command accepted while previous one still in progress");

  // a new result beat only comes from the final state
  assert property (@(posedge clk) disable iff (rst)
    out_load |-> (state == ST_LOAD) && (!out_valid || !out_stall))
    else $error("result loaded over a pending beat");

  // a character echo is only reported with success
  assert property (@(posedge clk) disable iff (rst)
    out_valid && (char_echo != 8'd0) |-> ok)
    else $error("character echo without success");

  // the fill sweep never runs past its limit
  assert property (@(posedge clk) disable iff (rst)
    (state == ST_FILL) |-> (fill_cnt <= fill_lim))
    else $error("fill counter beyond limit");

  // glyph pixel writes stay inside the store
  assert property (@(posedge clk) disable iff (rst)
    fb_we && (state == ST_PIX_WR) |-> (prod < 16'(FRAME_BYTES)))
    else $error("pixel write outside frame store");

endmodule

FILE: tb/sv/tb_mono_framebuffer_text_rasterizer.sv
`timescale 1ns / 100ps
// self-checking bench for mono_framebuffer_text_rasterizer: directed and random command beats,
// each result beat scored against an in-bench shadow of frame, font, cursor and registers
// depends on mfb_pkg and the rtl of the block only

module tb_mono_framebuffer_text_rasterizer;
  import mfb_pkg::*;

  localparam int CYCLE_LIMIT = 5_000_000;  // far beyond the slowest legal run
  localparam int TAIL_CYCLES = 40;         // quiet cycles after the last result beat
  localparam int IDLE_PCT    = 27;         // chance per cycle that a side idles

  // one command beat as driven on the input channel
  typedef struct packed {
    logic [2:0]  command;
    logic [7:0]  pos_x;
    logic [7:0]  pos_y;
    logic        ink;
    logic [7:0]  char_code;
    logic [11:0] font_index;
    logic [15:0] font_bits;
    logic [9:0]  read_index;
  } cmd_beat_t;

  // one result beat as seen on the output channel
  typedef struct packed {
    logic       ok;
    logic [7:0] char_echo;
    logic [7:0] read_byte;
  } result_beat_t;

  // dut signals, the inputs all at known values from time zero
  logic        clk;
  logic        rst        = 1'b1;
  logic        cfg_write  = 1'b0;
  cfg_idx_t    cfg_index  = CFG_WIDTH;
  logic [7:0]  cfg_data   = 8'd0;
  logic        in_valid   = 1'b0;
  logic        in_stall;
  logic [2:0]  command    = CMD_PIXEL;
  logic [7:0]  pos_x      = 8'd0;
  logic [7:0]  pos_y      = 8'd0;
  logic        ink        = 1'b0;
  logic [7:0]  char_code  = 8'd0;
  logic [11:0] font_index = 12'd0;
  logic [15:0] font_bits  = 16'd0;
  logic [9:0]  read_index = 10'd0;
  logic        out_valid;
  logic        out_stall  = 1'b0;
  logic        ok;
  logic [7:0]  char_echo;
  logic [7:0]  read_byte;

  // shadow of the block: stores, cursor and registers
  logic [7:0]  frame_shadow [FRAME_BYTES_DEF];
  logic [15:0] font_shadow  [FONT_WORDS_DEF];
  bit          font_written [FONT_WORDS_DEF];
  int          cur_col = 0;
  int          cur_row = 0;
  int          disp_w  = WIDTH_RST;
  int          disp_h  = HEIGHT_RST;
  int          glyph_w = GLYPH_W_RST;
  int          glyph_h = GLYPH_H_RST;

  result_beat_t pending_results [$];  // predicted beats, oldest first
  int           err_count  = 0;
  int           cycles     = 0;
  int           sent_count = 0;       // command beats accepted so far
  bit           steady_run = 1'b0;    // no idling on either side while set

  mono_framebuffer_text_rasterizer u_top (
    .clk        (clk),
    .rst        (rst),
    .cfg_write  (cfg_write),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .command    (command),
    .pos_x      (pos_x),
    .pos_y      (pos_y),
    .ink        (ink),
    .char_code  (char_code),
    .font_index (font_index),
    .font_bits  (font_bits),
    .read_index (read_index),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .ok         (ok),
    .char_echo  (char_echo),
    .read_byte  (read_byte)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // shadow of the block
  // ---------------------------------------------------------------------------

  // one pixel into the page layout: bit (y % 8) of byte x + (y / 8) * width
  function automatic bit plot_pixel(int x, int y, bit color);
    int addr;
    if (x >= disp_w || y >= disp_h) return 1'b0;
    addr = x + (y / 8) * disp_w;
    if (addr >= FRAME_BYTES_DEF) return 1'b0;
    frame_shadow[addr][y % 8] = color;
    return 1'b1;
  endfunction

  // glyph at the cursor, msb first; columns past bit 0 of the row read as clear
  function automatic bit render_glyph(int code, bit color);
    int          base;
    logic [15:0] bits;
    bit          on;
    if (disp_w < cur_col + glyph_w || disp_h < cur_row + glyph_h) return 1'b0;
    if (code < FIRST_CHAR_DEF) return 1'b0;
    base = (code - FIRST_CHAR_DEF) * glyph_h;
    if (base + glyph_h > FONT_WORDS_DEF) return 1'b0;
    for (int r = 0; r < glyph_h; r++) begin
      bits = font_shadow[base + r];
      for (int c = 0; c < glyph_w; c++) begin
        on = (c < 16) ? bits[15 - c] : 1'b0;
        void'(plot_pixel(cur_col + c, cur_row + r, on ? color : !color));
      end
    end
    cur_col = (cur_col + glyph_w) & 'hFF;
    return 1'b1;
  endfunction

  // runs one accepted command on the shadow and gives the beat it must answer with
  function automatic result_beat_t execute_on_shadow(cmd_beat_t b);
    result_beat_t res;
    int           n;
    res = '0;
    case (b.command)
      CMD_PIXEL: res.ok = plot_pixel(b.pos_x, b.pos_y, b.ink);
      CMD_CURSOR: begin
        cur_col = b.pos_x;
        cur_row = b.pos_y;
        res.ok  = 1'b1;
      end
      CMD_CHAR: begin
        if (render_glyph(b.char_code, b.ink)) begin
          res.ok        = 1'b1;
          res.char_echo = b.char_code;
        end
      end
      CMD_FILL: begin
        n = (disp_w * disp_h) / 8;
        if (n > FRAME_BYTES_DEF) n = FRAME_BYTES_DEF;
        for (int i = 0; i < n; i++) frame_shadow[i] = b.ink ? FILL_WHITE : FILL_BLACK;
        res.ok = 1'b1;
      end
      CMD_FONT: begin
        if (b.font_index < FONT_WORDS_DEF) begin
          font_shadow[b.font_index]  = b.font_bits;
          font_written[b.font_index] = 1'b1;
          res.ok = 1'b1;
        end
      end
      default: ;  // unknown codes change nothing
    endcase
    // readback sees the store after the command
    if (b.read_index < FRAME_BYTES_DEF) res.read_byte = frame_shadow[b.read_index];
    return res;
  endfunction

  // ---------------------------------------------------------------------------
  // channel drivers
  // ---------------------------------------------------------------------------

  // result side: random stall, driven at the falling edge
  always @(negedge clk) begin
    out_stall <= steady_run ? 1'b0 : ($urandom_range(99) < IDLE_PCT);
  end

  // send one command beat; prediction happens at the accepting edge
  task automatic send_cmd(input cmd_beat_t b);
    int gap;
    gap = 0;
    if (!steady_run) while ($urandom_range(99) < IDLE_PCT) gap++;
    if (gap > 0) begin
      @(negedge clk);
      in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_valid   <= 1'b1;
    command    <= b.command;
    pos_x      <= b.pos_x;
    pos_y      <= b.pos_y;
    ink        <= b.ink;
    char_code  <= b.char_code;
    font_index <= b.font_index;
    font_bits  <= b.font_bits;
    read_index <= b.read_index;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    pending_results.push_back(execute_on_shadow(b));
    sent_count++;
  endtask

  // drop valid and hold off until every predicted beat has come back
  task automatic wait_results_drained();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  task automatic cfg_poke(input cfg_idx_t idx, input logic [7:0] val);
    @(negedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
  endtask

  // all four registers, only with the block idle
  task automatic apply_config(input int w, input int h, input int gw, input int gh);
    wait_results_drained();
    cfg_poke(CFG_WIDTH, 8'(w));
    cfg_poke(CFG_HEIGHT, 8'(h));
    cfg_poke(CFG_GLYPH_W, 8'(gw));
    cfg_poke(CFG_GLYPH_H, 8'(gh));
    @(negedge clk);
    cfg_write <= 1'b0;
    disp_w  = w & 'hFF;
    disp_h  = h & 'h7F;
    glyph_w = gw & 'h1F;
    glyph_h = gh & 'h3F;
  endtask

  // ---------------------------------------------------------------------------
  // result checking
  // ---------------------------------------------------------------------------

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("mismatch %s: got 0x%0h want 0x%0h (cycle %0d)", what, got, want, cycles);
    err_count++;
  endtask

  always @(posedge clk) begin : score_result
    result_beat_t want;
    if (!rst && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        report_mismatch("result beat with nothing pending", 0, 0);
      end else begin
        want = pending_results.pop_front();
        if (ok !== want.ok) report_mismatch("ok", ok, want.ok);
        if (char_echo !== want.char_echo) report_mismatch("char_echo", char_echo, want.char_echo);
        if (read_byte !== want.read_byte) report_mismatch("read_byte", read_byte, want.read_byte);
      end
    end
  end

  // hang guard
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // stimulus helpers
  // ---------------------------------------------------------------------------

  // every field random; callers pick the command
  function automatic cmd_beat_t random_beat();
    cmd_beat_t b;
    b.command    = CMD_PIXEL;
    b.pos_x      = 8'($urandom_range(255));
    b.pos_y      = 8'($urandom_range(255));
    b.ink        = 1'($urandom_range(1));
    b.char_code  = 8'($urandom_range(255));
    b.font_index = 12'($urandom_range(4095));
    b.font_bits  = 16'($urandom);
    b.read_index = 10'($urandom_range(1023));
    return b;
  endfunction

  // byte that holds pixel (x, y) under the current width
  function automatic logic [9:0] byte_at(input int x, input int y);
    return 10'((x + (y / 8) * disp_w) % FRAME_BYTES_DEF);
  endfunction

  // mostly a small set of codes so loaded glyphs get reused
  function automatic int pick_code();
    if ($urandom_range(99) < 85) return FIRST_CHAR_DEF + $urandom_range(7);
    return $urandom_range(255);
  endfunction

  task automatic send_pixel(input int x, input int y, input bit color);
    cmd_beat_t b;
    b            = random_beat();
    b.command    = CMD_PIXEL;
    b.pos_x      = 8'(x);
    b.pos_y      = 8'(y);
    b.ink        = color;
    b.read_index = byte_at(x, y);
    send_cmd(b);
  endtask

  task automatic set_cursor(input int x, input int y);
    cmd_beat_t b;
    b         = random_beat();
    b.command = CMD_CURSOR;
    b.pos_x   = 8'(x);
    b.pos_y   = 8'(y);
    send_cmd(b);
  endtask

  task automatic send_fill(input bit color);
    cmd_beat_t b;
    b         = random_beat();
    b.command = CMD_FILL;
    b.ink     = color;
    send_cmd(b);
  endtask

  task automatic send_font(input int idx, input logic [15:0] bits);
    cmd_beat_t b;
    b            = random_beat();
    b.command    = CMD_FONT;
    b.font_index = 12'(idx);
    b.font_bits  = bits;
    send_cmd(b);
  endtask

  // the glyph's rows must hold data before any write char can read them
  task automatic load_glyph_rows(input int code);
    int base;
    if (code < FIRST_CHAR_DEF) return;
    base = (code - FIRST_CHAR_DEF) * glyph_h;
    if (base + glyph_h > FONT_WORDS_DEF) return;
    for (int r = 0; r < glyph_h; r++) begin
      if (!font_written[base + r]) send_font(base + r, 16'($urandom));
    end
  endtask

  // write char, readback aimed inside or just past the glyph cell
  task automatic put_char(input int code, input bit color);
    cmd_beat_t b;
    load_glyph_rows(code);
    b            = random_beat();
    b.command    = CMD_CHAR;
    b.char_code  = 8'(code);
    b.ink        = color;
    b.read_index = byte_at(cur_col + $urandom_range(glyph_w), cur_row + $urandom_range(glyph_h));
    send_cmd(b);
  endtask

  // weighted random commands; cursor beats are followed by a short text run
  // count covers every beat sent, glyph row loads included
  task automatic random_mix(input int count);
    int        start;
    int        pick;
    int        lim_x;
    int        lim_y;
    cmd_beat_t b;
    start = sent_count;
    while (sent_count - start < count) begin
      pick = $urandom_range(99);
      b    = random_beat();
      if (pick < 25) begin
        // mostly on screen, sometimes anywhere
        b.command = CMD_PIXEL;
        if ($urandom_range(3) != 0) begin
          b.pos_x = 8'($urandom_range(disp_w - 1));
          b.pos_y = 8'($urandom_range(disp_h - 1));
        end
        if ($urandom_range(1)) b.read_index = byte_at(b.pos_x, b.pos_y);
        send_cmd(b);
      end else if (pick < 60) begin
        // place the cursor, mostly where a glyph fits, then a run of characters
        lim_x = disp_w - glyph_w;
        lim_y = disp_h - glyph_h;
        if (lim_x < 0) lim_x = 0;
        if (lim_y < 0) lim_y = 0;
        if ($urandom_range(4) != 0) set_cursor($urandom_range(lim_x), $urandom_range(lim_y));
        else set_cursor(b.pos_x, b.pos_y);
        repeat ($urandom_range(4, 1)) begin
          put_char(pick_code(), 1'($urandom_range(1)));
        end
      end else if (pick < 65) begin
        send_fill(b.ink);
      end else if (pick < 85) begin
        // stray font rows anywhere in the store
        b.command = CMD_FONT;
        send_cmd(b);
      end else if (pick < 93) begin
        // lone character at wherever the cursor is, any code
        put_char($urandom_range(255), b.ink);
      end else begin
        b.command = 3'(CMD_FONT + $urandom_range(3, 1));
        send_cmd(b);
      end
    end
  endtask

  task automatic random_phase(input int w, input int h, input int gw, input int gh,
                              input int count);
    apply_config(w, h, gw, gh);
    random_mix(count);
  endtask

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------

  // reset config covers the whole frame store, so this fill makes every byte readable
  task automatic test_fill_after_reset();
    send_fill(1'b1);
    send_fill(1'b0);
  endtask

  // opposite corners, one past each edge and the far end of both coordinates
  task automatic test_pixel_bounds();
    send_pixel(0, 0, 1'b1);
    send_pixel(disp_w - 1, disp_h - 1, 1'b1);
    send_pixel(disp_w, 0, 1'b1);
    send_pixel(0, disp_h, 1'b1);
    send_pixel(255, 255, 1'b1);
    send_pixel(disp_w - 1, disp_h - 1, 1'b0);
  endtask

  task automatic test_unknown_commands();
    cmd_beat_t b;
    for (int k = 1; k <= 3; k++) begin
      b         = random_beat();
      b.command = 3'(CMD_FONT + k);
      send_cmd(b);
    end
  endtask

  task automatic test_glyph_rendering();
    send_fill(1'b0);
    // codes below the font are refused
    set_cursor(0, 0);
    put_char(0, 1'b1);
    put_char(FIRST_CHAR_DEF - 1, 1'b1);
    // 16 x 2 glyph with all-set and all-clear rows, placed flush to the corner
    apply_config(WIDTH_RST, HEIGHT_RST, 16, 2);
    send_font(FONT_WORDS_DEF - 1, 16'hA5A5);
    send_font(2, 16'hFFFF);
    send_font(3, 16'h0000);
    set_cursor(WIDTH_RST - 16, HEIGHT_RST - 2);
    put_char(FIRST_CHAR_DEF + 1, 1'b0);
    // cursor has moved off the right edge: no space
    put_char(FIRST_CHAR_DEF + 1, 1'b1);
  endtask

  task automatic test_config_extremes();
    // glyph wider than sixteen on a frame larger than the store
    apply_config(200, 64, 24, 2);
    set_cursor(176, 56);
    put_char(FIRST_CHAR_DEF + 1, 1'b1);
    send_pixel(199, 63, 1'b1);
    send_fill(1'b1);
    // tall glyph of the last code runs past the font store
    apply_config(WIDTH_RST, HEIGHT_RST, 7, 20);
    set_cursor(0, 0);
    put_char(255, 1'b1);
    // one-pixel-wide frame, glyph taller than the frame: never fits
    apply_config(1, 8, 1, 32);
    set_cursor(0, 0);
    put_char(FIRST_CHAR_DEF, 1'b1);
    send_pixel(0, 7, 1'b1);
    send_fill(1'b0);
  endtask

  task automatic test_random_traffic();
    // reset geometry, first part with no idling at all
    apply_config(WIDTH_RST, HEIGHT_RST, GLYPH_W_RST, GLYPH_H_RST);
    steady_run = 1'b1;
    random_mix(120);
    steady_run = 1'b0;
    random_mix(130);
    random_phase(1, 8, 1, 1, 80);
    random_phase(128, 64, 16, 32, 60);
    // mid-phase pause until the pipe is empty
    apply_config(64, 32, 5, 8);
    random_mix(120);
    wait_results_drained();
    random_mix(130);
    random_phase(200, 64, 20, 4, 100);
    repeat (3) begin
      random_phase($urandom_range(128, 1), 8 * $urandom_range(8, 1),
                   $urandom_range(16, 1), $urandom_range(32, 1), 80);
    end
  endtask

  // ---------------------------------------------------------------------------
  // sequence
  // ---------------------------------------------------------------------------

  initial begin
    repeat (5) @(negedge clk);
    rst <= 1'b0;
    test_fill_after_reset();
    test_pixel_bounds();
    test_unknown_commands();
    test_glyph_rendering();
    test_config_extremes();
    test_random_traffic();
    wait_results_drained();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (err_count == 0 && pending_results.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
